// ===== rtl/ep2t_pkg.sv =====
// Package for the Euler pose to transform block.
// Holds CORDIC constants and the arctangent table; no dependencies.
`default_nettype none
package ep2t_pkg;
  localparam int unsigned CordicSteps = 24;
  localparam int unsigned CordicW     = 34;
  localparam logic signed [CordicW-1:0] CordicKinv = 34'sd652032874;
  localparam int unsigned TurnW = 33;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic signed [TurnW-1:0] atan_turn(input int unsigned idx);
    logic signed [TurnW-1:0] r;
    r = '0;
    case (idx)
      0:  r = 33'sd536870912;
      1:  r = 33'sd316933406;
      2:  r = 33'sd167458907;
      3:  r = 33'sd85004756;
      4:  r = 33'sd42667331;
      5:  r = 33'sd21354465;
      6:  r = 33'sd10679838;
      7:  r = 33'sd5340245;
      8:  r = 33'sd2670163;
      9:  r = 33'sd1335087;
      10: r = 33'sd667544;
      11: r = 33'sd333772;
      12: r = 33'sd166886;
      13: r = 33'sd83443;
      14: r = 33'sd41722;
      15: r = 33'sd20861;
      16: r = 33'sd10430;
      17: r = 33'sd5215;
      18: r = 33'sd2608;
      19: r = 33'sd1304;
      20: r = 33'sd652;
      21: r = 33'sd326;
      22: r = 33'sd163;
      23: r = 33'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/euler_pose_to_transform_top.sv =====
// Euler pose (Z-Y-X) to 3x4 homogeneous transform, fully pipelined.
// Depends on ep2t_pkg.
//
//  channel | valid   | stall   | payload
//  in      | valid_i | stall_o | yaw_i pitch_i roll_i offset_x/y/z_i
//  out     | valid_o | stall_i | rot_00_o..rot_22_o shift_x/y/z_o
//
// Stages: 1 angle stage, 24 CORDIC stages (one per micro-rotation), 1 rounding/quadrant stage,
// 2 product stages, 1 sum stage, 1 output stage.
// One item per cycle while stall_i is low. Reset clears the valid bits only.
// A stall freezes the whole pipeline; stall_o follows stall_i.
`default_nettype none
module euler_pose_to_transform_top #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned COEF_BITS  = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      stall_o,
  input  wire logic signed [15:0] yaw_i,
  input  wire logic signed [15:0] pitch_i,
  input  wire logic signed [15:0] roll_i,
  input  wire logic signed [31:0] offset_x_i,
  input  wire logic signed [31:0] offset_y_i,
  input  wire logic signed [31:0] offset_z_i,
  output logic      valid_o,
  input  wire logic stall_i,
  output logic signed [COEF_BITS-1:0] rot_00_o,
  output logic signed [COEF_BITS-1:0] rot_01_o,
  output logic signed [COEF_BITS-1:0] rot_02_o,
  output logic signed [COEF_BITS-1:0] rot_10_o,
  output logic signed [COEF_BITS-1:0] rot_11_o,
  output logic signed [COEF_BITS-1:0] rot_12_o,
  output logic signed [COEF_BITS-1:0] rot_20_o,
  output logic signed [COEF_BITS-1:0] rot_21_o,
  output logic signed [COEF_BITS-1:0] rot_22_o,
  output logic signed [31:0] shift_x_o,
  output logic signed [31:0] shift_y_o,
  output logic signed [31:0] shift_z_o
);
  localparam int unsigned Steps = ep2t_pkg::CordicSteps;
  localparam int unsigned CW    = ep2t_pkg::CordicW;
  localparam int unsigned TW    = ep2t_pkg::TurnW;
  localparam int unsigned Frac  = COEF_BITS - 2;
  localparam int unsigned CDrop = 30 - Frac;
  // sin/cos after rounding, plus one guard bit
  localparam int unsigned SW    = COEF_BITS + 1;
  localparam int unsigned PW    = 2 * SW;
  // exact sums of rounded products fit comfortably here
  localparam int unsigned EW    = SW + 3;
  localparam int unsigned Depth = Steps + 6;
  localparam int unsigned AbitsIn = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;

  logic adv;
  assign adv     = ~stall_i;
  assign stall_o = stall_i;

  // valid shift line
  logic [Depth-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end
  assign valid_o = vld_q[Depth-1];

  // translation rides alongside
  logic [95:0] ofs_q [Depth];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ofs_q[0] <= {offset_x_i, offset_y_i, offset_z_i};
      for (int k = 1; k < Depth; k++) ofs_q[k] <= ofs_q[k-1];
    end
  end
  assign shift_x_o = ofs_q[Depth-1][95:64];
  assign shift_y_o = ofs_q[Depth-1][63:32];
  assign shift_z_o = ofs_q[Depth-1][31:0];

  // angle to turn word, quadrant split
  function automatic logic [31:0] to_turn(input logic [15:0] raw);
    logic [31:0] a;
    a = '0;
    a[AbitsIn-1:0] = raw[AbitsIn-1:0];
    return a << (32 - ANGLE_BITS);
  endfunction

  logic [1:0]          quad_q [3][Steps+1];
  logic signed [TW-1:0] z_q   [3][Steps+1];
  logic signed [CW-1:0] x_q   [3][Steps+1];
  logic signed [CW-1:0] y_q   [3][Steps+1];
  logic [15:0] ang [3];
  assign ang[0] = yaw_i;
  assign ang[1] = pitch_i;
  assign ang[2] = roll_i;

  logic signed [SW-1:0] c_q [3];
  logic signed [SW-1:0] s_q [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [31:0] turn, dres;
    logic [1:0]  quad;
    assign turn = to_turn(ang[a]);
    assign quad = 2'((turn + 32'h2000_0000) >> 30);
    assign dres = turn - {quad, 30'd0};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        quad_q[a][0] <= quad;
        z_q[a][0]    <= TW'(signed'(dres));
        x_q[a][0]    <= ep2t_pkg::CordicKinv;
        y_q[a][0]    <= '0;
      end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < Steps; i++) begin : g_step
      logic signed [CW-1:0] xs, ys;
      assign xs = x_q[a][i] >>> i;
      assign ys = y_q[a][i] >>> i;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          quad_q[a][i+1] <= quad_q[a][i];
          if (!z_q[a][i][TW-1]) begin
            x_q[a][i+1] <= x_q[a][i] - ys;
            y_q[a][i+1] <= y_q[a][i] + xs;
            z_q[a][i+1] <= z_q[a][i] - ep2t_pkg::atan_turn(i);
          end else begin
            x_q[a][i+1] <= x_q[a][i] + ys;
            y_q[a][i+1] <= y_q[a][i] - xs;
            z_q[a][i+1] <= z_q[a][i] + ep2t_pkg::atan_turn(i);
          end
        end
      end
    end

    // round to Frac bits and apply quadrant
    logic signed [CW-1:0] xr, yr;
    logic signed [SW-1:0] cr, sr;
    assign xr = (x_q[a][Steps] + (CW'(1) << (CDrop - 1))) >>> CDrop;
    assign yr = (y_q[a][Steps] + (CW'(1) << (CDrop - 1))) >>> CDrop;
    assign cr = SW'(xr);
    assign sr = SW'(yr);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        case (quad_q[a][Steps])
          2'd0: begin c_q[a] <= cr;  s_q[a] <= sr;  end
          2'd1: begin c_q[a] <= -sr; s_q[a] <= cr;  end
          2'd2: begin c_q[a] <= -cr; s_q[a] <= -sr; end
          default: begin c_q[a] <= sr; s_q[a] <= -cr; end
        endcase
      end
    end
  end

  function automatic logic signed [SW-1:0] rmul(input logic signed [SW-1:0] p,
                                                input logic signed [SW-1:0] q);
    logic signed [PW-1:0] m;
    m = (PW'(p) * PW'(q)) + (PW'(1) <<< (Frac - 1));
    return SW'(m >>> Frac);
  endfunction

  // first product stage
  logic signed [SW-1:0] cycp_q, sycp_q, cysp_q, sysp_q, sycr_q, sysr_q;
  logic signed [SW-1:0] cycr_q, cysr_q, cpsr_q, cpcr_q, nsp_q, sr1_q, cr1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cycp_q <= rmul(c_q[0], c_q[1]);
      sycp_q <= rmul(s_q[0], c_q[1]);
      cysp_q <= rmul(c_q[0], s_q[1]);
      sysp_q <= rmul(s_q[0], s_q[1]);
      sycr_q <= rmul(s_q[0], c_q[2]);
      sysr_q <= rmul(s_q[0], s_q[2]);
      cycr_q <= rmul(c_q[0], c_q[2]);
      cysr_q <= rmul(c_q[0], s_q[2]);
      cpsr_q <= rmul(c_q[1], s_q[2]);
      cpcr_q <= rmul(c_q[1], c_q[2]);
      nsp_q  <= -s_q[1];
      sr1_q  <= s_q[2];
      cr1_q  <= c_q[2];
    end
  end

  // second product stage
  logic signed [SW-1:0] t01_q, t02_q, t11_q, t12_q;
  logic signed [SW-1:0] p00_q, p10_q, p20_q, p21_q, p22_q;
  logic signed [SW-1:0] u01_q, u02_q, u11_q, u12_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t01_q <= rmul(cysp_q, sr1_q);
      t02_q <= rmul(cysp_q, cr1_q);
      t11_q <= rmul(sysp_q, sr1_q);
      t12_q <= rmul(sysp_q, cr1_q);
      u01_q <= sycr_q;  u02_q <= sysr_q;
      u11_q <= cycr_q;  u12_q <= cysr_q;
      p00_q <= cycp_q;  p10_q <= sycp_q;  p20_q <= nsp_q;
      p21_q <= cpsr_q;  p22_q <= cpcr_q;
    end
  end

  // sums
  logic signed [EW-1:0] e_q [9];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_q[0] <= EW'(p00_q);
      e_q[1] <= EW'(t01_q) - EW'(u01_q);
      e_q[2] <= EW'(t02_q) + EW'(u02_q);
      e_q[3] <= EW'(p10_q);
      e_q[4] <= EW'(t11_q) + EW'(u11_q);
      e_q[5] <= EW'(t12_q) - EW'(u12_q);
      e_q[6] <= EW'(p20_q);
      e_q[7] <= EW'(p21_q);
      e_q[8] <= EW'(p22_q);
    end
  end

  function automatic logic signed [COEF_BITS-1:0] sat(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] hi, lo;
    hi = EW'({1'b0, {(COEF_BITS-1){1'b1}}});
    lo = -hi - EW'(1);
    if (v > hi) return COEF_BITS'(hi);
    if (v < lo) return COEF_BITS'(lo);
    return COEF_BITS'(v);
  endfunction

  // saturated output register
  logic signed [COEF_BITS-1:0] rot_q [9];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) rot_q[k] <= sat(e_q[k]);
    end
  end
  assign rot_00_o = rot_q[0];
  assign rot_01_o = rot_q[1];
  assign rot_02_o = rot_q[2];
  assign rot_10_o = rot_q[3];
  assign rot_11_o = rot_q[4];
  assign rot_12_o = rot_q[5];
  assign rot_20_o = rot_q[6];
  assign rot_21_o = rot_q[7];
  assign rot_22_o = rot_q[8];
endmodule
`default_nettype wire

// ===== bench/euler_pose_to_transform_top_tb.sv =====
// Self-checking bench for euler_pose_to_transform_top: poses in, 3x4 transforms out.
// Depends on the RTL top level only; predicts transforms with its own CORDIC model or takes them from the table.
`default_nettype none
module euler_pose_to_transform_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracBits = 14;
  localparam int unsigned Steps    = 24;
  localparam longint      KinvQ30  = 652032874;
  localparam int unsigned Latency  = 30;
  localparam int unsigned NumRand  = 440;  // per idling phase

  // idling phases
  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  typedef struct {
    logic signed [15:0] yaw, pitch, roll;
    logic signed [31:0] ox, oy, oz;
  } pose_t;

  typedef struct {
    logic signed [15:0] rot [9];
    logic signed [31:0] shift [3];
  } xform_t;

  typedef struct {
    pose_t  pose;
    logic   typed;     // expected transform given in the table
    xform_t want;
  } pose_row_t;

  // arctangent of 2^-i, 2^-32 turn units
  localparam longint AtanTurn [Steps] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic signed [15:0] yaw_i = '0, pitch_i = '0, roll_i = '0;
  logic signed [31:0] offset_x_i = '0, offset_y_i = '0, offset_z_i = '0;
  logic stall_o, valid_o;
  logic signed [15:0] rot_o [9];
  logic signed [31:0] shift_o [3];

  idle_mode_e idle_mode = IdleNone;
  xform_t     pending_xforms [$];
  int unsigned mismatch_cnt = 0;
  int unsigned checked_cnt  = 0;

  euler_pose_to_transform_top u_top (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .yaw_i, .pitch_i, .roll_i, .offset_x_i, .offset_y_i, .offset_z_i,
    .valid_o, .stall_i,
    .rot_00_o(rot_o[0]), .rot_01_o(rot_o[1]), .rot_02_o(rot_o[2]),
    .rot_10_o(rot_o[3]), .rot_11_o(rot_o[4]), .rot_12_o(rot_o[5]),
    .rot_20_o(rot_o[6]), .rot_21_o(rot_o[7]), .rot_22_o(rot_o[8]),
    .shift_x_o(shift_o[0]), .shift_y_o(shift_o[1]), .shift_z_o(shift_o[2])
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // round half up from s fraction bits
  function automatic longint round_down(longint v, int unsigned s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_down(a * b, FracBits);
  endfunction

  function automatic logic signed [15:0] clip_coef(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // cosine and sine of a binary angle, Q2.14
  function automatic void angle_cos_sin(input logic [15:0] ang, output longint c,
                                        output longint s);
    logic [31:0] turn, resid;
    logic [1:0]  quad;
    longint x, y, z, xs, ys, cr, sr;
    turn  = {ang, 16'h0000};
    quad  = 2'((turn + 32'h2000_0000) >> 30);
    resid = turn - {quad, 30'h0};
    z = longint'($signed(resid));
    x = KinvQ30;
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= AtanTurn[i];
      end else begin
        x += ys; y -= xs; z += AtanTurn[i];
      end
    end
    cr = round_down(x, 30 - FracBits);
    sr = round_down(y, 30 - FracBits);
    case (quad)
      2'd0: begin c = cr;  s = sr;  end
      2'd1: begin c = -sr; s = cr;  end
      2'd2: begin c = -cr; s = -sr; end
      default: begin c = sr; s = -cr; end
    endcase
  endfunction

  // Z-Y-X rotation plus translation pass-through
  function automatic xform_t pose_to_xform(pose_t p);
    xform_t t;
    longint cy, sy, cp, sp, cr, sr;
    angle_cos_sin(p.yaw, cy, sy);
    angle_cos_sin(p.pitch, cp, sp);
    angle_cos_sin(p.roll, cr, sr);
    t.rot[0] = clip_coef(qmul(cy, cp));
    t.rot[1] = clip_coef(qmul(qmul(cy, sp), sr) - qmul(sy, cr));
    t.rot[2] = clip_coef(qmul(qmul(cy, sp), cr) + qmul(sy, sr));
    t.rot[3] = clip_coef(qmul(sy, cp));
    t.rot[4] = clip_coef(qmul(qmul(sy, sp), sr) + qmul(cy, cr));
    t.rot[5] = clip_coef(qmul(qmul(sy, sp), cr) - qmul(cy, sr));
    t.rot[6] = clip_coef(-sp);
    t.rot[7] = clip_coef(qmul(cp, sr));
    t.rot[8] = clip_coef(qmul(cp, cr));
    t.shift[0] = p.ox;
    t.shift[1] = p.oy;
    t.shift[2] = p.oz;
    return t;
  endfunction

  function automatic int unsigned idle_pct(logic receiver);
    case (idle_mode)
      IdleSender:   return receiver ? 0 : 82;
      IdleReceiver: return receiver ? 82 : 0;
      IdleBoth:     return 26;
      default:      return 0;
    endcase
  endfunction

  // receiver stall
  always @(posedge clk_i) begin
    stall_i <= ($urandom_range(99) < idle_pct(1'b1));
  end

  // present one pose, hold it until accepted, then queue its transform
  task automatic send_pose(pose_t p, logic typed, xform_t want);
    while ($urandom_range(99) < idle_pct(1'b0)) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i    <= 1'b1;
    yaw_i      <= p.yaw;
    pitch_i    <= p.pitch;
    roll_i     <= p.roll;
    offset_x_i <= p.ox;
    offset_y_i <= p.oy;
    offset_z_i <= p.oz;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    pending_xforms.push_back(typed ? want : pose_to_xform(p));
  endtask

  // angles near the quadrant seams and range ends, or fully random
  function automatic logic [15:0] pick_angle();
    logic [15:0] a;
    a = 16'($urandom);
    if ($urandom_range(3) == 0)
      a = {3'($urandom_range(7)), 13'h0} + 16'($signed($urandom_range(8)) - 4);
    return a;
  endfunction

  // check each transform against the oldest prediction
  always @(posedge clk_i) begin
    xform_t w;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_xforms.size() == 0) begin
        $error("transform with no pose pending");
        mismatch_cnt++;
      end else begin
        w = pending_xforms.pop_front();
        checked_cnt++;
        for (int i = 0; i < 9; i++)
          if (rot_o[i] !== w.rot[i]) begin
            $error("rot_%0d%0d: expected %0d, got %0d", i / 3, i % 3, w.rot[i], rot_o[i]);
            mismatch_cnt++;
          end
        for (int i = 0; i < 3; i++)
          if (shift_o[i] !== w.shift[i]) begin
            $error("shift_%s: expected %0d, got %0d", i == 0 ? "x" : i == 1 ? "y" : "z",
                   w.shift[i], shift_o[i]);
            mismatch_cnt++;
          end
      end
    end
  end

  initial begin
    pose_row_t rows [$];
    pose_row_t r;
    xform_t    ident, none;
    pose_t     p;
    int        waited;
    int        a [] = '{0, 8192, 16384, 24576, -32768, -24576, -16384, -8192, 32767,
                        -1, 1, 4096, -4096, 12288};

    // identity rotation for zero angles
    foreach (ident.rot[i]) ident.rot[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;

    // directed table
    r.typed = 1'b1;
    r.pose = '{16'sd0, 16'sd0, 16'sd0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000};
    r.want = ident;
    r.want.shift = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000};
    rows.push_back(r);
    r.pose = '{16'sd0, 16'sd0, 16'sd0, -32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa};
    r.want.shift = '{-32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa};
    rows.push_back(r);
    r.typed = 1'b0;
    foreach (a[i]) begin
      r.pose = '{16'(a[i]), 16'(a[(i + 3) % a.size()]), 16'(a[(i + 7) % a.size()]),
                 32'(i), 32'(-i), 32'(i << 20)};
      rows.push_back(r);
    end
    r.pose = '{-16'sd32768, -16'sd32768, -16'sd32768, 32'sd0, 32'sd0, 32'sd0};
    rows.push_back(r);
    r.pose = '{16'sd32767, 16'sd32767, 16'sd32767, 32'sd0, 32'sd0, 32'sd0};
    rows.push_back(r);
    // gimbal lock, all ninety degrees
    r.pose = '{16'sd16384, 16'sd16384, 16'sd16384, 32'sd1, 32'sd2, 32'sd3};
    rows.push_back(r);
    // pitch at minus ninety
    r.pose = '{16'sd5461, -16'sd16384, 16'sd2730, 32'sd0, 32'sd0, 32'sd0};
    rows.push_back(r);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_pose(rows[i].pose, rows[i].typed, rows[i].want);

    // random poses in every idling phase
    for (int m = IdleNone; m <= IdleBoth; m++) begin
      idle_mode = idle_mode_e'(m);
      for (int n = 0; n < NumRand; n++) begin
        p.yaw   = pick_angle();
        p.pitch = pick_angle();
        p.roll  = pick_angle();
        p.ox = 32'($urandom);
        p.oy = 32'($urandom);
        p.oz = 32'($urandom);
        send_pose(p, 1'b0, none);
      end
    end
    valid_i <= 1'b0;

    // drain
    waited = 0;
    while (pending_xforms.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (2 * Latency) @(posedge clk_i);

    $display("Ran %0d directed and %0d random poses over four idling phases;",
             rows.size(), 4 * NumRand);
    $display("%0d transforms checked, %0d mismatches, %0d still pending.",
             checked_cnt, mismatch_cnt, pending_xforms.size());
    if (mismatch_cnt == 0 && pending_xforms.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
